[src/bsisp_pkg.sv]
package bsisp_pkg;

    // Time base and policy constants
    localparam int TIME_BITS        = 32;
    localparam int EVAL_INTERVAL_MS = 500;
    localparam int EXIT_MARGIN      = 5;
    localparam int PCT_MAX          = 100;
    localparam int MS_PER_S         = 1000;

    localparam int PCT_BITS      = 7;
    localparam int SECS_BITS     = 16;
    localparam int GRACE_BITS    = 16;
    localparam int SLEEP_MS_BITS = 26;   // 65535 s * 1000 fits in 26 bits
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [TIME_BITS-1:0]     t_time;
    typedef logic [PCT_BITS-1:0]      t_pct;
    typedef logic [SLEEP_MS_BITS-1:0] t_sleep_ms;

    // Request actions
    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_ACTIVITY = 2'd1,
        ACT_RECONFIG = 2'd2
    } t_action;

    // Power modes
    typedef enum logic [1:0] {
        PM_OFF    = 2'd0,
        PM_FORCED = 2'd1,
        PM_AUTO   = 2'd2
    } t_power_mode;

    // Standby modes
    typedef enum logic [1:0] {
        SM_NONE   = 2'd0,
        SM_IDLE   = 2'd1,
        SM_SAVING = 2'd2
    } t_sleep_mode;

    // Reason codes of the last evaluation
    typedef enum logic [3:0] {
        RSN_OFF       = 4'd0,
        RSN_FORCED    = 4'd1,
        RSN_GAUGE_OFF = 4'd2,
        RSN_NO_PACK   = 4'd3,
        RSN_CHARGED   = 4'd4,
        RSN_CHARGING  = 4'd5,
        RSN_ABOVE     = 4'd6,
        RSN_AT_BELOW  = 4'd7,
        RSN_HOLD      = 4'd8
    } t_reason;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_POWER_MODE  = 3'd0,
        CFG_THRESHOLD   = 3'd1,
        CFG_SLEEP_MODE  = 3'd2,
        CFG_SLEEP_AFTER = 3'd3,
        CFG_AUDIO_GRACE = 3'd4,
        CFG_WAKE_BUTTON = 3'd5
    } t_cfg_idx;

    // Decoded configuration seen by the policy logic
    typedef struct packed {
        logic [1:0]            power_mode;
        logic [1:0]            sleep_mode;
        t_pct                  thr_sat;
        t_pct                  exit_pct;
        t_sleep_ms             sleep_after_ms;
        logic [GRACE_BITS-1:0] audio_grace_ms;
        logic                  wake_button;
    } t_cfg;

    // One request
    typedef struct packed {
        logic [1:0] action;
        t_time      now_ms;
        logic       gauge_enabled;
        logic       pack_present;
        logic       charging;
        logic       charge_done;
        t_pct       charge_percent;
        t_time      audio_heard_ms;
        logic       player_active;
    } t_item;

    // Policy decision
    typedef struct packed {
        logic    saving;
        logic    blind;
        t_reason reason;
    } t_policy;

    // One result
    typedef struct packed {
        logic       saving;
        logic       gauge_blind;
        logic [3:0] reason_code;
        t_pct       exit_percent;
        logic       evaluated;
        logic       sleep_request;
        t_time      idle_ms;
    } t_result;

endpackage

[src/bsisp_cfg.sv]
module bsisp_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bsisp_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [bsisp_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata,
    output bsisp_pkg::t_cfg                     o_cfg
);

    bsisp_pkg::t_cfg r_cfg, n_cfg;
    bsisp_pkg::t_pct w_thr_sat;
    logic [bsisp_pkg::PCT_BITS:0] w_exit_sum;

    // Saturate the threshold and derive the exit point at write time
    always_comb begin
        if (i_cfg_wdata[bsisp_pkg::PCT_BITS-1:0] > bsisp_pkg::t_pct'(bsisp_pkg::PCT_MAX)) begin
            w_thr_sat = bsisp_pkg::t_pct'(bsisp_pkg::PCT_MAX);
        end else begin
            w_thr_sat = i_cfg_wdata[bsisp_pkg::PCT_BITS-1:0];
        end
        w_exit_sum = {1'b0, w_thr_sat} + (bsisp_pkg::PCT_BITS+1)'(bsisp_pkg::EXIT_MARGIN);
    end

    // Decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                bsisp_pkg::CFG_POWER_MODE: begin
                    n_cfg.power_mode = i_cfg_wdata[1:0];
                end
                bsisp_pkg::CFG_THRESHOLD: begin
                    n_cfg.thr_sat = w_thr_sat;
                    if (w_exit_sum > (bsisp_pkg::PCT_BITS+1)'(bsisp_pkg::PCT_MAX)) begin
                        n_cfg.exit_pct = bsisp_pkg::t_pct'(bsisp_pkg::PCT_MAX);
                    end else begin
                        n_cfg.exit_pct = w_exit_sum[bsisp_pkg::PCT_BITS-1:0];
                    end
                end
                bsisp_pkg::CFG_SLEEP_MODE: begin
                    n_cfg.sleep_mode = i_cfg_wdata[1:0];
                end
                bsisp_pkg::CFG_SLEEP_AFTER: begin
                    n_cfg.sleep_after_ms =
                        bsisp_pkg::t_sleep_ms'(i_cfg_wdata[bsisp_pkg::SECS_BITS-1:0])
                        * bsisp_pkg::t_sleep_ms'(bsisp_pkg::MS_PER_S);
                end
                bsisp_pkg::CFG_AUDIO_GRACE: begin
                    n_cfg.audio_grace_ms = i_cfg_wdata[bsisp_pkg::GRACE_BITS-1:0];
                end
                bsisp_pkg::CFG_WAKE_BUTTON: begin
                    n_cfg.wake_button = i_cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Hold the registers, reset to the power-up settings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_mode     <= bsisp_pkg::PM_OFF;
            r_cfg.sleep_mode     <= bsisp_pkg::SM_NONE;
            r_cfg.thr_sat        <= bsisp_pkg::t_pct'(20);
            r_cfg.exit_pct       <= bsisp_pkg::t_pct'(25);
            r_cfg.sleep_after_ms <= bsisp_pkg::t_sleep_ms'(600 * bsisp_pkg::MS_PER_S);
            r_cfg.audio_grace_ms <= bsisp_pkg::GRACE_BITS'(3000);
            r_cfg.wake_button    <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/bsisp_eval.sv]
module bsisp_eval (
    input  bsisp_pkg::t_cfg    i_cfg,
    input  bsisp_pkg::t_item   i_item,
    input  logic               i_saving,
    output bsisp_pkg::t_policy o_pol
);

    logic w_at_below;
    logic w_on;

    // Hysteresis: enter at or below threshold, leave only at or above the exit point
    assign w_at_below = i_item.charge_percent <= i_cfg.thr_sat;
    assign w_on       = i_saving ? (i_item.charge_percent < i_cfg.exit_pct) : w_at_below;

    always_comb begin
        o_pol.saving = 1'b0;
        o_pol.blind  = 1'b0;
        o_pol.reason = bsisp_pkg::RSN_OFF;
        case (i_cfg.power_mode)
            bsisp_pkg::PM_FORCED: begin
                o_pol.saving = 1'b1;
                o_pol.reason = bsisp_pkg::RSN_FORCED;
            end
            bsisp_pkg::PM_AUTO: begin
                if (!i_item.gauge_enabled) begin
                    o_pol.blind  = 1'b1;
                    o_pol.reason = bsisp_pkg::RSN_GAUGE_OFF;
                end else if (!i_item.pack_present) begin
                    o_pol.blind  = 1'b1;
                    o_pol.reason = bsisp_pkg::RSN_NO_PACK;
                end else if (i_item.charge_done) begin
                    o_pol.reason = bsisp_pkg::RSN_CHARGED;
                end else if (i_item.charging) begin
                    o_pol.reason = bsisp_pkg::RSN_CHARGING;
                end else begin
                    o_pol.saving = w_on;
                    if (!w_on) begin
                        o_pol.reason = bsisp_pkg::RSN_ABOVE;
                    end else if (w_at_below) begin
                        o_pol.reason = bsisp_pkg::RSN_AT_BELOW;
                    end else begin
                        o_pol.reason = bsisp_pkg::RSN_HOLD;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[src/bsisp_core.sv]
module bsisp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  bsisp_pkg::t_item   i_item,
    input  bsisp_pkg::t_cfg    i_cfg,
    output bsisp_pkg::t_result o_res
);

    logic                r_saving, n_saving;
    logic                r_blind, n_blind;
    bsisp_pkg::t_reason  r_reason, n_reason;
    bsisp_pkg::t_time    r_last_eval, n_last_eval;
    bsisp_pkg::t_time    r_activity, n_activity;
    logic                r_sleep_started, n_sleep_started;

    bsisp_pkg::t_policy  w_pol;
    bsisp_pkg::t_time    w_since_eval;
    bsisp_pkg::t_time    w_since_audio;
    bsisp_pkg::t_time    w_idle_old;
    logic                w_tick_go;
    logic                w_do_eval;
    logic                w_busy;
    logic                w_req;

    bsisp_eval u_eval (
        .i_cfg    (i_cfg),
        .i_item   (i_item),
        .i_saving (r_saving),
        .o_pol    (w_pol)
    );

    // Throttle ticks to one evaluation per interval
    assign w_since_eval = i_item.now_ms - r_last_eval;
    assign w_tick_go    = (i_item.action == bsisp_pkg::ACT_TICK)
                       && (w_since_eval >= bsisp_pkg::t_time'(bsisp_pkg::EVAL_INTERVAL_MS));
    assign w_do_eval    = w_tick_go || (i_item.action == bsisp_pkg::ACT_RECONFIG);

    // Audio heard recently or player running counts as busy
    assign w_since_audio = i_item.now_ms - i_item.audio_heard_ms;
    assign w_busy = ((i_item.audio_heard_ms != '0)
                     && (w_since_audio < bsisp_pkg::t_time'(i_cfg.audio_grace_ms)))
                 || i_item.player_active;
    assign w_idle_old = i_item.now_ms - r_activity;

    // Next state: policy, timestamps and standby countdown
    always_comb begin
        n_saving        = r_saving;
        n_blind         = r_blind;
        n_reason        = r_reason;
        n_last_eval     = r_last_eval;
        n_activity      = r_activity;
        n_sleep_started = r_sleep_started;
        w_req           = 1'b0;
        if (w_do_eval) begin
            n_saving    = w_pol.saving;
            n_blind     = w_pol.blind;
            n_reason    = w_pol.reason;
            n_last_eval = i_item.now_ms;
        end
        if (i_item.action == bsisp_pkg::ACT_ACTIVITY
                || i_item.action == bsisp_pkg::ACT_RECONFIG) begin
            n_activity = i_item.now_ms;
        end
        // Service the countdown on an evaluating tick only
        if (w_tick_go && !r_sleep_started && i_cfg.wake_button
                && (i_cfg.sleep_mode == bsisp_pkg::SM_IDLE
                    || i_cfg.sleep_mode == bsisp_pkg::SM_SAVING)) begin
            if (i_cfg.sleep_mode == bsisp_pkg::SM_SAVING && !w_pol.saving) begin
                n_activity = i_item.now_ms;
            end else if (w_busy) begin
                n_activity = i_item.now_ms;
            end else if (w_idle_old >= bsisp_pkg::t_time'(i_cfg.sleep_after_ms)) begin
                n_sleep_started = 1'b1;
                w_req           = 1'b1;
            end
        end
    end

    // Build the result
    always_comb begin
        o_res.saving        = n_saving;
        o_res.gauge_blind   = n_blind;
        o_res.reason_code   = n_reason;
        o_res.exit_percent  = i_cfg.exit_pct;
        o_res.evaluated     = w_do_eval;
        o_res.sleep_request = w_req;
        o_res.idle_ms       = i_item.now_ms - n_activity;
    end

    // Advance the state when a request moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saving        <= 1'b0;
            r_blind         <= 1'b0;
            r_reason        <= bsisp_pkg::RSN_OFF;
            r_last_eval     <= '0;
            r_activity      <= '0;
            r_sleep_started <= 1'b0;
        end else if (i_fire) begin
            r_saving        <= n_saving;
            r_blind         <= n_blind;
            r_reason        <= n_reason;
            r_last_eval     <= n_last_eval;
            r_activity      <= n_activity;
            r_sleep_started <= n_sleep_started;
        end
    end

    // Standby fires once and stays latched until reset
    a_sleep_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sleep_started |=> r_sleep_started)
        else $error("standby latch cleared without reset");

    // A standby request only comes from an evaluating tick
    a_req_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req |-> (w_tick_go && w_pol.saving == n_saving))
        else $error("standby request without evaluating tick");

    // Blind flag goes with a gauge or pack reason only
    a_blind_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blind |-> (r_reason == bsisp_pkg::RSN_GAUGE_OFF
                     || r_reason == bsisp_pkg::RSN_NO_PACK))
        else $error("blind flag with wrong reason");

    // Saving is on only for forced, at or below, or hold
    a_saving_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_saving |-> (r_reason == bsisp_pkg::RSN_FORCED
                      || r_reason == bsisp_pkg::RSN_AT_BELOW
                      || r_reason == bsisp_pkg::RSN_HOLD))
        else $error("saving active with inconsistent reason");

endmodule

[src/battery_save_and_idle_sleep_policy.sv]
// Channel   Direction  Handshake                   Payload
// request   in         i_in_valid / o_in_stall     i_action .. i_player_active
// result    out        o_out_valid / i_out_stall   o_saving .. o_idle_ms
// config    in         i_cfg_we (no wait)          i_cfg_index, i_cfg_wdata
//
// One request per cycle sustained while the result channel is not stalled; the
// request lands in the input register at its accept edge, and the result
// register loads after the policy logic once it frees and presents the result.
// Reset is synchronous, active low; it restores power-up settings and clears
// the policy state and the standby latch. No clearing pass is needed.
// A stalled result holds in the output register while one more request waits
// in the input register; o_in_stall rises only when both are full.
module battery_save_and_idle_sleep_policy (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_action,
    input  logic [bsisp_pkg::TIME_BITS-1:0]     i_now_ms,
    input  logic                                i_gauge_enabled,
    input  logic                                i_pack_present,
    input  logic                                i_charging,
    input  logic                                i_charge_done,
    input  logic [bsisp_pkg::PCT_BITS-1:0]      i_charge_percent,
    input  logic [bsisp_pkg::TIME_BITS-1:0]     i_audio_heard_ms,
    input  logic                                i_player_active,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_saving,
    output logic                                o_gauge_blind,
    output logic [3:0]                          o_reason_code,
    output logic [bsisp_pkg::PCT_BITS-1:0]      o_exit_percent,
    output logic                                o_evaluated,
    output logic                                o_sleep_request,
    output logic [bsisp_pkg::TIME_BITS-1:0]     o_idle_ms,
    // configuration port
    input  logic                                i_cfg_we,
    input  logic [bsisp_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [bsisp_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata
);

    logic                r_in_vld;
    bsisp_pkg::t_item    r_item;
    logic                r_out_vld;
    bsisp_pkg::t_result  r_res;

    bsisp_pkg::t_cfg     w_cfg;
    bsisp_pkg::t_result  w_res;
    logic                w_adv;
    logic                w_fire;
    logic                w_in_take;

    bsisp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    bsisp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // Handshake: result register frees when empty or taken
    assign w_adv      = !r_out_vld || !i_out_stall;
    assign w_fire     = r_in_vld && w_adv;
    assign o_in_stall = r_in_vld && !w_adv;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_take) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item.action         <= i_action;
            r_item.now_ms         <= i_now_ms;
            r_item.gauge_enabled  <= i_gauge_enabled;
            r_item.pack_present   <= i_pack_present;
            r_item.charging       <= i_charging;
            r_item.charge_done    <= i_charge_done;
            r_item.charge_percent <= i_charge_percent;
            r_item.audio_heard_ms <= i_audio_heard_ms;
            r_item.player_active  <= i_player_active;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_saving        = r_res.saving;
    assign o_gauge_blind   = r_res.gauge_blind;
    assign o_reason_code   = r_res.reason_code;
    assign o_exit_percent  = r_res.exit_percent;
    assign o_evaluated     = r_res.evaluated;
    assign o_sleep_request = r_res.sleep_request;
    assign o_idle_ms       = r_res.idle_ms;

endmodule
